@@ rtl/core/ircansi_pkg.sv @@
// Shared types, character codes and the color table for the chat-text to
// terminal-escape converter. No dependencies.
package ircansi_pkg;

   typedef enum logic [1:0] {
      PH_TEXT   = 2'd0,
      PH_START  = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SEG_NONE = 2'd0,
      SEG_BYTE = 2'd1,
      SEG_CRLF = 2'd2,
      SEG_ESC  = 2'd3
   } seg_kind_type;

   typedef struct packed {
      seg_kind_type     kind;
      logic [7:0]       byte_val;
      logic [1:0]       ndig;
      logic [2:0][3:0]  dig;
   } seg_type;

   typedef struct packed {
      logic [1:0]       last_seg;
      seg_type [2:0]    seg;
   } cmd_type;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [7:0] CH_BOLD      = 8'h02;
   localparam logic [7:0] CH_COLOR     = 8'h03;
   localparam logic [7:0] CH_BELL      = 8'h07;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_RESET     = 8'h0F;
   localparam logic [7:0] CH_REVERSE   = 8'h16;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_UNDERLINE = 8'h1F;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_M         = 8'h6D;

   function automatic logic [4:0] color_map(input logic [3:0] idx);
      logic [4:0] m;
      case (idx)
         4'd0:    m = 5'd7;
         4'd1:    m = 5'd0;
         4'd2:    m = 5'd4;
         4'd3:    m = 5'd2;
         4'd4:    m = 5'd1;
         4'd5:    m = 5'd3;
         4'd6:    m = 5'd5;
         4'd7:    m = 5'd11;
         4'd8:    m = 5'd13;
         4'd9:    m = 5'd12;
         4'd10:   m = 5'd6;
         4'd11:   m = 5'd16;
         4'd12:   m = 5'd14;
         4'd13:   m = 5'd15;
         4'd14:   m = 5'd10;
         default: m = 5'd7;
      endcase
      return m;
   endfunction

   function automatic seg_type esc_seg(input logic [1:0] ndig, input logic [3:0] d0,
                                       input logic [3:0] d1, input logic [3:0] d2);
      seg_type s;
      s.kind     = SEG_ESC;
      s.byte_val = '0;
      s.ndig     = ndig;
      s.dig[0]   = d0;
      s.dig[1]   = d1;
      s.dig[2]   = d2;
      return s;
   endfunction

   function automatic seg_type byte_seg(input seg_kind_type kind, input logic [7:0] b);
      seg_type s;
      s          = '0;
      s.kind     = kind;
      s.byte_val = b;
      return s;
   endfunction

endpackage

@@ rtl/core/ircansi_front.sv @@
// Front end: parses input bytes, keeps color and attribute state, and turns
// each beat into a command of up to three output segments. Uses ircansi_pkg.
module ircansi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                end_of_text,
   input  logic                cfg_we,
   input  logic                cfg_data,
   output logic                push,
   output ircansi_pkg::cmd_type cmd
);
   import ircansi_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] dcount_ff, dcount_in;
   logic [6:0] cnum_ff, cnum_in;
   logic       bg_ff, bg_in;
   logic       bold_ff, bold_in;
   logic       uline_ff, uline_in;
   logic       rev_ff, rev_in;
   logic       filter_ff;

   seg_type    esc1, plain_seg, tail_seg, color_seg;
   logic       do_plain, is_digit;
   logic [3:0] dval;
   logic [4:0] mapped;
   logic [3:0] low_ones;
   logic [1:0] nseg;

   assign is_digit = char_byte inside {[CH_ZERO:CH_NINE]};
   assign dval     = char_byte[3:0];
   assign mapped   = color_map(cnum_ff[3:0]);
   assign low_ones = 4'(mapped - 5'd10);

   always_comb begin
      if (dcount_ff == 2'd0) begin
         color_seg = esc_seg(2'd0, 4'd0, 4'd0, 4'd0);
      end else if (mapped > 5'd9) begin
         color_seg = bg_ff ? esc_seg(2'd3, 4'd1, 4'd0, low_ones)
                           : esc_seg(2'd2, 4'd9, low_ones, 4'd0);
      end else begin
         color_seg = esc_seg(2'd2, bg_ff ? 4'd4 : 4'd3, mapped[3:0], 4'd0);
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      dcount_in = dcount_ff;
      cnum_in   = cnum_ff;
      bg_in     = bg_ff;
      bold_in   = bold_ff;
      uline_in  = uline_ff;
      rev_in    = rev_ff;
      esc1      = '0;
      plain_seg = '0;
      tail_seg  = '0;
      do_plain  = 1'b0;
      case (phase_ff)
         PH_START: begin
            if (is_digit) begin
               cnum_in   = {3'd0, dval};
               dcount_in = 2'd1;
               bg_in     = 1'b0;
               phase_in  = PH_DIGITS;
            end else begin
               esc1     = esc_seg(2'd0, 4'd0, 4'd0, 4'd0);
               phase_in = PH_TEXT;
               do_plain = 1'b1;
            end
         end
         PH_DIGITS: begin
            if (is_digit && dcount_ff < 2'd2) begin
               cnum_in   = 7'((cnum_ff << 3) + (cnum_ff << 1) + {3'd0, dval});
               dcount_in = dcount_ff + 2'd1;
            end else begin
               esc1      = color_seg;
               dcount_in = 2'd0;
               cnum_in   = '0;
               if (char_byte == CH_COMMA) begin
                  bg_in = 1'b1;
               end else begin
                  phase_in = PH_TEXT;
                  do_plain = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_TEXT;
            do_plain = 1'b1;
         end
      endcase

      if (do_plain) begin
         case (char_byte)
            CH_COLOR: phase_in = PH_START;
            CH_REVERSE: begin
               plain_seg = rev_ff ? esc_seg(2'd2, 4'd2, 4'd7, 4'd0)
                                  : esc_seg(2'd1, 4'd7, 4'd0, 4'd0);
               rev_in = !rev_ff;
            end
            CH_UNDERLINE: begin
               plain_seg = uline_ff ? esc_seg(2'd2, 4'd2, 4'd4, 4'd0)
                                    : esc_seg(2'd1, 4'd4, 4'd0, 4'd0);
               uline_in = !uline_ff;
            end
            CH_BOLD: begin
               plain_seg = bold_ff ? esc_seg(2'd2, 4'd2, 4'd2, 4'd0)
                                   : esc_seg(2'd1, 4'd1, 4'd0, 4'd0);
               bold_in = !bold_ff;
            end
            CH_BELL: begin
               if (!filter_ff) begin
                  plain_seg = byte_seg(SEG_BYTE, char_byte);
               end
            end
            CH_RESET: begin
               plain_seg = esc_seg(2'd0, 4'd0, 4'd0, 4'd0);
               bold_in   = 1'b0;
               uline_in  = 1'b0;
               rev_in    = 1'b0;
            end
            CH_TAB:  plain_seg = byte_seg(SEG_BYTE, CH_SPACE);
            CH_LF:   plain_seg = byte_seg(SEG_CRLF, CH_LF);
            default: plain_seg = byte_seg(SEG_BYTE, char_byte);
         endcase
      end

      if (end_of_text) begin
         if (phase_in == PH_START) begin
            tail_seg = esc_seg(2'd0, 4'd0, 4'd0, 4'd0);
         end
         phase_in  = PH_TEXT;
         dcount_in = '0;
         cnum_in   = '0;
         bg_in     = 1'b0;
         bold_in   = 1'b0;
         uline_in  = 1'b0;
         rev_in    = 1'b0;
      end
   end

   // pack nonempty segments to the front of the command
   always_comb begin
      cmd  = '0;
      nseg = 2'd0;
      if (esc1.kind != SEG_NONE) begin
         cmd.seg[nseg] = esc1;
         nseg          = nseg + 2'd1;
      end
      if (plain_seg.kind != SEG_NONE) begin
         cmd.seg[nseg] = plain_seg;
         nseg          = nseg + 2'd1;
      end
      if (tail_seg.kind != SEG_NONE) begin
         cmd.seg[nseg] = tail_seg;
         nseg          = nseg + 2'd1;
      end
      cmd.last_seg = nseg - 2'd1;
   end

   assign push = accept && (nseg != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TEXT;
         dcount_ff <= '0;
         cnum_ff   <= '0;
         bg_ff     <= 1'b0;
         bold_ff   <= 1'b0;
         uline_ff  <= 1'b0;
         rev_ff    <= 1'b0;
         filter_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            dcount_ff <= dcount_in;
            cnum_ff   <= cnum_in;
            bg_ff     <= bg_in;
            bold_ff   <= bold_in;
            uline_ff  <= uline_in;
            rev_ff    <= rev_in;
         end
         if (cfg_we) begin
            filter_ff <= cfg_data;
         end
      end
   end

endmodule

@@ rtl/core/ircansi_queue.sv @@
// Short command queue between front and back end.
// Uses ircansi_pkg for the command type and depth.
module ircansi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ircansi_pkg::cmd_type push_cmd,
   input  logic                pop,
   output logic                full,
   output logic                valid,
   output ircansi_pkg::cmd_type head
);
   import ircansi_pkg::*;

   cmd_type      mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ff, rd_ff;
   logic [QAW:0]   count_ff;

   assign full  = count_ff == (QAW+1)'(QDEPTH);
   assign valid = count_ff != '0;
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QAW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QAW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QAW+1)'(1);
            2'b01:   count_ff <= count_ff - (QAW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/core/ircansi_back.sv @@
// Back end: walks the segments of the head command and emits one output byte
// per beat into the output register. Uses ircansi_pkg.
module ircansi_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  ircansi_pkg::cmd_type q_cmd,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import ircansi_pkg::*;

   logic [1:0] seg_idx_ff, seg_idx_in;
   logic [2:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       last_ff;

   seg_type    cur;
   logic [2:0] seg_len;
   logic [1:0] dpos;
   logic [7:0] out_b;
   logic       seg_end, run_end, advance;

   assign cur     = q_cmd.seg[seg_idx_ff];
   assign advance = q_valid && (!valid_ff || rsp_tready);
   assign dpos    = pos_ff[1:0] - 2'd2;

   always_comb begin
      case (cur.kind)
         SEG_BYTE: seg_len = 3'd1;
         SEG_CRLF: seg_len = 3'd2;
         SEG_ESC:  seg_len = {1'b0, cur.ndig} + 3'd3;
         default:  seg_len = 3'd1;
      endcase
   end

   always_comb begin
      case (cur.kind)
         SEG_CRLF: out_b = (pos_ff == 3'd0) ? CH_CR : CH_LF;
         SEG_ESC: begin
            if (pos_ff == 3'd0) begin
               out_b = CH_ESC;
            end else if (pos_ff == 3'd1) begin
               out_b = CH_LBRACKET;
            end else if (pos_ff == seg_len - 3'd1) begin
               out_b = CH_M;
            end else begin
               case (dpos)
                  2'd0:    out_b = {4'h3, cur.dig[0]};
                  2'd1:    out_b = {4'h3, cur.dig[1]};
                  default: out_b = {4'h3, cur.dig[2]};
               endcase
            end
         end
         default: out_b = cur.byte_val;
      endcase
   end

   assign seg_end = pos_ff == seg_len - 3'd1;
   assign run_end = seg_end && (seg_idx_ff == q_cmd.last_seg);
   assign q_pop   = advance && run_end;

   always_comb begin
      seg_idx_in = seg_idx_ff;
      pos_in     = pos_ff;
      valid_in   = valid_ff && !rsp_tready;
      if (advance) begin
         valid_in = 1'b1;
         if (!seg_end) begin
            pos_in = pos_ff + 3'd1;
         end else begin
            pos_in     = '0;
            seg_idx_in = run_end ? 2'd0 : seg_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_idx_ff <= '0;
         pos_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         seg_idx_ff <= seg_idx_in;
         pos_ff     <= pos_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= out_b;
         last_ff <= run_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/core/irc_format_to_ansi_escape.sv @@
// Chat-text to terminal-escape converter, top level.
// An accepted beat's command is registered in the queue, its first output byte
// then in the output register. Throughput: one byte per cycle while rsp_tready
// is high, bounded by the single-byte output register; an input beat yields 0
// to 11 bytes. Input is taken every cycle while the 4-entry queue has room.
// Reset (synchronous): clears parse state, attributes, filter_beep, queue, output.
module irc_format_to_ansi_escape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // last_of_run
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // filter_beep
);
   import ircansi_pkg::*;

   logic    accept, push, full, q_valid, q_pop;
   cmd_type push_cmd, q_head;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ircansi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_byte   (req_tdata),
      .end_of_text (req_tlast),
      .cfg_we      (csr_valid && csr_ready),
      .cfg_data    (csr_data),
      .push        (push),
      .cmd         (push_cmd)
   );

   ircansi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (full),
      .valid    (q_valid),
      .head     (q_head)
   );

   ircansi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/ircansi_checker.sv @@
// Port-level checks for the converter top level, attached by bind.
// Depends only on the top level's ports.
module ircansi_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       csr_valid,
   input logic       csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not cleared by reset");

   a_full_drains: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no output pending");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind irc_format_to_ansi_escape ircansi_checker u_ircansi_checker (.*);
